// File: hdl/pcm_downmix_box_decimator_assert.svh
// Assertion macros for the PCM downmix box decimator checker.
// Include-guarded; needs clk and rst in the scope of each use.
`ifndef PCM_DOWNMIX_BOX_DECIMATOR_ASSERT_SVH
`define PCM_DOWNMIX_BOX_DECIMATOR_ASSERT_SVH

// Check a property outside reset
`define PDBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included
`define PDBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pdbd_pkg.sv
// Shared types and constants for the PCM downmix box decimator.
// No dependencies; imported by every module of the block.
package pdbd_pkg;

  // Width of one downmixed sample L+R (or 2*L), signed
  localparam int SAMPLE_W = 17;

  localparam logic [1:0] CHANNEL_MONO      = 2'd1;
  localparam logic [1:0] CHANNEL_COUNT_RST = 2'd2;
  localparam logic [4:0] RATIO_RST         = 5'd4;

  // Register index taken from paddr[2]
  typedef enum logic {
    REG_CHANNEL_COUNT    = 1'b0,
    REG_DECIMATION_RATIO = 1'b1
  } pdbd_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DELIVER
  } pdbd_state_t;

  typedef struct packed {
    logic [1:0] channel_count;
    logic [4:0] decimation_ratio;
    logic       chan_write;
  } pdbd_cfg_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic out_load;
  } pdbd_cmd_t;

  typedef struct packed {
    logic group_done;
    logic out_free;
  } pdbd_status_t;

endpackage

// File: hdl/pdbd_regs.sv
// APB register file: channel count and decimation ratio.
// Depends on pdbd_pkg.
module pdbd_regs import pdbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output pdbd_cfg_t   cfg
);

  logic [1:0] channel_count;
  logic [4:0] decimation_ratio;
  logic       wr_en;
  pdbd_reg_t  reg_sel;

  assign reg_sel = pdbd_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write registers on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= CHANNEL_COUNT_RST;
      decimation_ratio <= RATIO_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_CHANNEL_COUNT:    channel_count    <= pwdata[1:0];
        REG_DECIMATION_RATIO: decimation_ratio <= pwdata[4:0];
        default:              channel_count    <= channel_count;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_CHANNEL_COUNT:    prdata = {30'd0, channel_count};
      REG_DECIMATION_RATIO: prdata = {27'd0, decimation_ratio};
      default:              prdata = 32'd0;
    endcase
  end

  // A channel count write drops any partial frame in the same cycle
  assign cfg.channel_count    = channel_count;
  assign cfg.decimation_ratio = decimation_ratio;
  assign cfg.chan_write       = wr_en && (reg_sel == REG_CHANNEL_COUNT);

endmodule

// File: hdl/pdbd_ctrl.sv
// Controller: sequences byte intake, the divide iterations and result hand-off.
// Depends on pdbd_pkg.
module pdbd_ctrl import pdbd_pkg::*; #(
  parameter int STEPS = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  pdbd_status_t status,
  output pdbd_cmd_t    cmd
);

  localparam int SCW = (STEPS > 1) ? $clog2(STEPS) : 1;

  pdbd_state_t    state, state_next;
  logic [SCW-1:0] step_cnt, step_cnt_next;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.group_done) begin
          state_next    = ST_DIVIDE;
          step_cnt_next = SCW'(STEPS - 1);
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_DELIVER;
        end else begin
          step_cnt_next = step_cnt - 1'b1;
        end
      end
      ST_DELIVER: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/pdbd_datapath.sv
// Datapath: frame assembly, downmix, group accumulation, restoring divider
// and output register. Depends on pdbd_pkg.
module pdbd_datapath import pdbd_pkg::*; #(
  parameter int MAX_RATIO = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  logic               packet_good,
  input  logic               packet_end,
  input  pdbd_cfg_t          cfg,
  input  pdbd_cmd_t          cmd,
  output pdbd_status_t       status,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] mono_sample
);

  localparam int CW = $clog2(MAX_RATIO + 1);
  localparam int RW = (CW > 5) ? CW : 5;
  localparam int SW = SAMPLE_W + $clog2(MAX_RATIO);
  localparam int DW = CW + 1;

  logic [23:0]          frame_bytes, frame_bytes_next;
  logic [1:0]           byte_pos, byte_pos_next;
  logic signed [SW-1:0] group_sum, group_sum_next;
  logic [CW-1:0]        group_count, group_count_next;

  logic [DW-1:0]        div_rem;
  logic [SW-1:0]        div_quo;
  logic [DW-1:0]        div_den;
  logic                 div_neg;

  logic                       stereo, frame_last, take_byte;
  logic signed [15:0]         left, right;
  logic signed [SAMPLE_W-1:0] mix;
  logic signed [SW-1:0]       sum_inc;
  logic [SW-1:0]              sum_mag;
  logic [CW-1:0]              count_inc;
  logic [RW-1:0]              ratio_ext, ratio_eff;
  logic                       ratio_zero, group_end;
  logic [DW:0]                trial;
  logic [15:0]                quo_lo, result;

  // Downmix the frame completed by this byte
  assign stereo     = cfg.channel_count != CHANNEL_MONO;
  assign frame_last = stereo ? (byte_pos == 2'd3) : (byte_pos != 2'd0);
  assign left       = stereo ? $signed(frame_bytes[15:0])
                             : $signed({data_byte, frame_bytes[7:0]});
  assign right      = $signed({data_byte, frame_bytes[23:16]});
  assign mix        = stereo ? (SAMPLE_W'(left) + SAMPLE_W'(right))
                             : (SAMPLE_W'(left) <<< 1);

  // Clamp the ratio to the group capacity
  assign ratio_ext  = RW'(cfg.decimation_ratio);
  assign ratio_eff  = (ratio_ext > RW'(MAX_RATIO)) ? RW'(MAX_RATIO) : ratio_ext;
  assign ratio_zero = ratio_eff == '0;

  assign sum_inc    = group_sum + SW'(mix);
  assign sum_mag    = sum_inc[SW-1] ? SW'(-sum_inc) : SW'(sum_inc);
  assign count_inc  = group_count + 1'b1;
  assign group_end  = packet_good && frame_last && !ratio_zero &&
                      (RW'(count_inc) >= ratio_eff);
  assign take_byte  = cmd.accept && packet_good;

  assign status.group_done = group_end;
  assign status.out_free   = !out_valid || out_ready;

  // Frame assembly and group accumulation
  always_comb begin
    frame_bytes_next = frame_bytes;
    byte_pos_next    = byte_pos;
    group_sum_next   = group_sum;
    group_count_next = group_count;
    if (take_byte) begin
      if (frame_last) begin
        frame_bytes_next = '0;
        byte_pos_next    = '0;
        if (ratio_zero || group_end) begin
          group_sum_next   = '0;
          group_count_next = '0;
        end else begin
          group_sum_next   = sum_inc;
          group_count_next = count_inc;
        end
      end else begin
        case (byte_pos)
          2'd0:    frame_bytes_next[7:0]   = data_byte;
          2'd1:    frame_bytes_next[15:8]  = data_byte;
          2'd2:    frame_bytes_next[23:16] = data_byte;
          default: frame_bytes_next        = frame_bytes;
        endcase
        byte_pos_next = byte_pos + 1'b1;
      end
    end
    // drop a partial frame at packet end, even for a bad packet
    if (cmd.accept && packet_end) begin
      frame_bytes_next = '0;
      byte_pos_next    = '0;
    end
    if (cfg.chan_write) begin
      byte_pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes <= '0;
      byte_pos    <= '0;
      group_sum   <= '0;
      group_count <= '0;
    end else begin
      frame_bytes <= frame_bytes_next;
      byte_pos    <= byte_pos_next;
      group_sum   <= group_sum_next;
      group_count <= group_count_next;
    end
  end

  // Restoring divider: one quotient bit per step, magnitude only
  assign trial = {div_rem, div_quo[SW-1]};

  always_ff @(posedge clk) begin
    if (take_byte && group_end) begin
      div_rem <= '0;
      div_quo <= sum_mag;
      div_den <= {count_inc, 1'b0};
      div_neg <= sum_inc[SW-1];
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, div_den}) begin
        div_rem <= DW'(trial - {1'b0, div_den});
        div_quo <= {div_quo[SW-2:0], 1'b1};
      end else begin
        div_rem <= trial[DW-1:0];
        div_quo <= {div_quo[SW-2:0], 1'b0};
      end
    end
  end

  // Restore the sign; truncation toward zero falls out of the magnitude divide
  assign quo_lo = div_quo[15:0];
  assign result = div_neg ? (~quo_lo + 16'd1) : quo_lo;

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mono_sample <= $signed(result);
    end
  end

endmodule

// File: hdl/pcm_downmix_box_decimator.sv
// PCM downmix box decimator, top level.
// Input channel: one payload byte per transaction (data_byte, packet_good,
// packet_end) on in_valid/in_ready. Little-endian 16-bit frames are built
// from good bytes, stereo frames averaged to mono, and groups of
// decimation_ratio samples averaged into one Q1.15 mono_sample on
// out_valid/out_ready. Registers sit on an APB port (pready always high).
// Intake: a byte that does not close a group is taken without dropping
// in_ready. A byte that closes a group holds in_ready low while the
// SW = 17 + clog2(MAX_RATIO) steps of the one-bit-per-cycle divider run
// and until the output register is free; the result becomes valid as
// in_ready rises again.
// When the receiver stalls, the result waits in the output register while
// bytes keep flowing; only a further finished group waits for it to drain.
// Reset (synchronous) clears the partial frame, the group and out_valid,
// and sets channel_count to 2 and decimation_ratio to 4.
// Depends on pdbd_pkg, pdbd_regs, pdbd_ctrl and pdbd_datapath.
module pcm_downmix_box_decimator import pdbd_pkg::*; #(
  parameter int MAX_RATIO = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               packet_good,
  input  logic               packet_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] mono_sample,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SW = SAMPLE_W + $clog2(MAX_RATIO);

  pdbd_cfg_t    cfg;
  pdbd_cmd_t    cmd;
  pdbd_status_t status;

  pdbd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pdbd_ctrl #(
    .STEPS (SW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pdbd_datapath #(
    .MAX_RATIO (MAX_RATIO)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .packet_good (packet_good),
    .packet_end  (packet_end),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .mono_sample (mono_sample)
  );

endmodule

// File: hdl/pdbd_checker.sv
// Port-level checker for the PCM downmix box decimator, bound to the top.
// Depends on pcm_downmix_box_decimator_assert.svh.
`include "pcm_downmix_box_decimator_assert.svh"

module pdbd_port_checks (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              packet_good,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] mono_sample,
  input logic              pready
);

  // Leave reset idle and empty
  `PDBD_ASSERT_ALWAYS(a_reset_idle, rst |=> (in_ready && !out_valid), "not idle after reset")

  // A stalled result holds
  `PDBD_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(mono_sample)), "stalled result changed")

  // A new result only follows a divide phase with intake held off
  `PDBD_ASSERT(a_result_after_divide, $rose(out_valid) |-> $past(!in_ready), "result without divide phase")

  // Intake stops only after a good byte closed a group
  `PDBD_ASSERT(a_stall_cause, $fell(in_ready) |-> $past(in_valid && packet_good), "intake stalled without a good byte")

  // Register port never waits
  `PDBD_ASSERT(a_pready_high, pready, "pready low")

endmodule

bind pcm_downmix_box_decimator pdbd_port_checks u_checker (.*);

// File: verif/pdbd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the PCM downmix box decimator: tracks register writes and
// accepted bytes, predicts each decimated sample and compares the output.
// Depends on pdbd_pkg for the register codes and reset values.
module pdbd_checker import pdbd_pkg::*; #(
  parameter int MAX_RATIO = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               packet_good,
  input  logic               packet_end,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] mono_sample,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 pending,
  output int                 fail_count
);

  // Predicted register contents and datapath state
  logic [1:0]         chan_cfg;
  logic [4:0]         ratio_cfg;
  logic [23:0]        frame_bytes;
  logic [1:0]         byte_pos;
  logic signed [21:0] group_sum;
  logic [4:0]         group_count;

  // Decimated samples still owed by the block, oldest first
  logic signed [15:0] owed_samples[$];

  // Add one downmixed sample to the running group; close it when full
  task automatic accumulate_sample(input logic signed [16:0] s);
    int eff_ratio;
    int quotient;
    eff_ratio = (ratio_cfg > MAX_RATIO) ? MAX_RATIO : int'(ratio_cfg);
    if (eff_ratio == 0) begin
      group_sum   = '0;
      group_count = '0;
    end else begin
      group_sum   = group_sum + s;
      group_count = group_count + 5'd1;
      if (int'(group_count) >= eff_ratio) begin
        // Integer division truncates toward zero
        quotient = int'(group_sum) / (2 * int'(group_count));
        owed_samples.insert(owed_samples.size(), quotient[15:0]);
        group_sum   = '0;
        group_count = '0;
      end
    end
  endtask

  // Assemble frames from good bytes; drop any partial frame at packet end
  task automatic absorb_byte(input logic [7:0] b, input logic good, input logic last);
    logic               stereo;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [16:0] s;
    stereo = (chan_cfg != CHANNEL_MONO);
    if (good) begin
      if (int'(byte_pos) + 1 >= (stereo ? 4 : 2)) begin
        left  = stereo ? frame_bytes[15:0] : {b, frame_bytes[7:0]};
        right = {b, frame_bytes[23:16]};
        if (stereo)
          s = {left[15], left} + {right[15], right};
        else
          s = {left, 1'b0};
        byte_pos    = '0;
        frame_bytes = '0;
        accumulate_sample(s);
      end else begin
        frame_bytes[8*byte_pos +: 8] = b;
        byte_pos = byte_pos + 2'd1;
      end
    end
    if (last) begin
      byte_pos    = '0;
      frame_bytes = '0;
    end
  endtask

  logic signed [15:0] want;

  always @(posedge clk) begin
    if (rst) begin
      chan_cfg    = CHANNEL_COUNT_RST;
      ratio_cfg   = RATIO_RST;
      frame_bytes = '0;
      byte_pos    = '0;
      group_sum   = '0;
      group_count = '0;
      owed_samples.delete();
      pending    <= 0;
      fail_count <= 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (pdbd_reg_t'(paddr[2]))
          REG_CHANNEL_COUNT: begin
            chan_cfg = pwdata[1:0];
            byte_pos = '0;
          end
          REG_DECIMATION_RATIO: ratio_cfg = pwdata[4:0];
          default: ;
        endcase
      end
      // Compare each output transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (owed_samples.size() == 0) begin
          $error("mono_sample: none expected, got %0d", mono_sample);
          fail_count <= fail_count + 1;
        end else begin
          want = owed_samples.pop_front();
          if (mono_sample !== want) begin
            $error("mono_sample: expected %0d, got %0d", want, mono_sample);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Predict from each input transaction
      if (in_valid && in_ready)
        absorb_byte(data_byte, packet_good, packet_end);
      pending <= owed_samples.size();
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for pcm_downmix_box_decimator: drives bytes, the
// output stall and APB register writes; pdbd_checker predicts and compares.
// Depends on pdbd_pkg, the block's RTL and pdbd_checker.
module tb_top;
  import pdbd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 110;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               packet_good;
  logic               packet_end;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] mono_sample;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int pending;
  int fail_count;
  int cycle_count;
  bit idle_on;
  bit mono_mode;

  pcm_downmix_box_decimator dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .packet_good (packet_good),
    .packet_end  (packet_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mono_sample (mono_sample),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  pdbd_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .packet_good (packet_good),
    .packet_end  (packet_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mono_sample (mono_sample),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiver: stall in random bursts while idling is enabled
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Present one byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b, input logic good, input logic last);
    @(negedge clk);
    in_valid    <= 1'b1;
    data_byte   <= b;
    packet_good <= good;
    packet_end  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk);
    end
  endtask

  // Drop valid, wait for every owed sample, then let the divider go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle
  task automatic apb_write(input pdbd_reg_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both registers with random upper bits, block idle
  task automatic configure(input logic [1:0] chan, input logic [4:0] ratio);
    logic [31:0] word;
    settle();
    word = $urandom;
    word[1:0] = chan;
    apb_write(REG_CHANNEL_COUNT, word);
    word = $urandom;
    word[4:0] = ratio;
    apb_write(REG_DECIMATION_RATIO, word);
    mono_mode = (chan == CHANNEL_MONO);
  endtask

  // Random byte, biased toward sample extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly whole-frame good packets; some ragged, bad, unterminated or noise
  task automatic run_traffic(input int n_items);
    int  sent;
    int  len;
    int  kind;
    int  frame_len;
    bit  good;
    bit  last;
    sent = 0;
    while (sent < n_items) begin
      frame_len = mono_mode ? 2 : 4;
      kind = $urandom_range(0, 11);
      if (kind < 8)
        len = frame_len * $urandom_range(1, 8);
      else
        len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        case (kind)
          9:       good = 1'b0;
          10:      good = 1'($urandom_range(0, 1));
          default: good = 1'b1;
        endcase
        if (kind == 10)
          last = $urandom_range(0, 3) == 0;
        else
          last = (i == len - 1) && kind != 7;
        send_byte(pick_byte(), good, last);
      end
      sent += len;
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = '0;
    packet_good = 1'b0;
    packet_end  = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_on     = 1'b1;
    mono_mode   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Stereo at reset ratio: most negative and most positive frames
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b1, 1'b0);
    // Bad byte inside a frame is skipped
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h80, 1'b1, 1'b1);
    // Partial frame dropped at packet end
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'hBB, 1'b1, 1'b1);
    // Ratio lowered mid-group: next mono sample closes the group
    configure(CHANNEL_MONO, 5'd1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h80, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b1, 1'b1);
    // Channel write drops a partial frame
    send_byte(8'h55, 1'b1, 1'b0);
    settle();
    apb_write(REG_CHANNEL_COUNT, 32'(CHANNEL_MONO));
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h02, 1'b1, 1'b1);
    // Ratio zero discards samples
    configure(CHANNEL_MONO, 5'd0);
    send_byte(8'h34, 1'b1, 1'b0);
    send_byte(8'h12, 1'b1, 1'b1);

    // Random phases over a spread of settings, extremes included
    configure(2'd2, 5'd16);
    run_traffic(PHASE_ITEMS);
    configure(CHANNEL_MONO, 5'd31);
    run_traffic(PHASE_ITEMS);
    configure(2'd0, 5'd1);
    idle_on = 1'b0;
    run_traffic(PHASE_ITEMS);
    idle_on = 1'b1;
    configure(2'd3, 5'd17);
    run_traffic(PHASE_ITEMS);
    configure(CHANNEL_MONO, 5'd0);
    run_traffic(PHASE_ITEMS / 2);
    configure(2'd2, 5'd3);
    run_traffic(PHASE_ITEMS);
    for (int p = 0; p < 4; p++) begin
      configure(2'($urandom_range(0, 3)), 5'($urandom_range(1, 20)));
      run_traffic(PHASE_ITEMS);
    end
    // Final stretch with no idling on either side
    idle_on = 1'b0;
    configure(CHANNEL_MONO, 5'd2);
    run_traffic(PHASE_ITEMS);

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
